// ===== rtl/asvd_pkg.sv =====
package asvd_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_STRETCH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLIFY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AXIS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HMIN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HMAX    = 3'd4;

  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    E_IDLE,
    E_START,
    E_MUL,
    E_RND,
    E_SUM,
    E_DIV,
    E_DRND,
    E_K
  } eng_state_t;

  typedef enum logic [1:0] {
    DT_AMP,
    DT_XY,
    DT_ZS
  } div_tgt_t;

endpackage

// ===== rtl/axis_stretch_vertex_deform.sv =====
// channel | direction | contents
// in_     | slave     | tdata: in_x, in_y, in_z (COORD_WIDTH each, from bit 0 up)
// out_    | master    | tdata: out_x, out_y, out_z; tuser: degenerate_box
// cfg_    | write     | cfg_addr selects register, cfg_wdata COORD_WIDTH bits
// one vertex per cycle when the output does not stall and the scale unit is idle
// the height division is a pipelined restoring divider, one quotient bit per stage
// after reset and after every cfg write the scale unit recomputes its factors with
// a serial divider (run twice when amplify_factor is negative), with in_tready
// low meanwhile
// reset is synchronous active low and clears control state and the pipeline valids
// an output stall freezes the whole pipeline, nothing is dropped or repeated
module axis_stretch_vertex_deform #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,   // in_x, in_y, in_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,  // out_x, out_y, out_z
  output logic                              out_tuser,  // degenerate_box
  input  logic                              cfg_we,
  input  logic [asvd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata
);
  import asvd_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * CW;
  localparam int DW  = ((3 * CW + 7) / 8) * 8;
  localparam int DCW = $clog2(2 * F + 1);

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW+1:0] MAXE = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] MINE = {3'b111, {(CW-1){1'b0}}};
  localparam logic signed [CW+1:0] ONE_E = {{(CW+1-F){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [PW:0] HALF_P = (PW+1)'(1) << (F - 1);
  localparam logic [PW-F:0] LIMN = (PW-F+1)'(1) << (CW - 1);
  localparam logic [PW-F:0] LIMP = LIMN - 1'b1;
  localparam logic [CW:0] QLIMN = (CW+1)'(1) << (CW - 1);
  localparam logic [CW:0] QLIMP = QLIMN - 1'b1;
  localparam logic [DCW-1:0] DTOP = DCW'(2 * F);

  function automatic logic [CW-1:0] mag_f(input logic signed [CW-1:0] a);
    mag_f = a[CW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic signed [CW+1:0] sx_f(input logic signed [CW-1:0] a);
    sx_f = {{2{a[CW-1]}}, a};
  endfunction

  function automatic logic signed [CW-1:0] sat_f(input logic signed [CW+1:0] a);
    if (a > MAXE) sat_f = CMAX;
    else if (a < MINE) sat_f = CMIN;
    else sat_f = a[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rnd_f(input logic neg, input logic [PW-1:0] p);
    logic [PW:0]   s;
    logic [PW-F:0] r;
    logic [PW-F:0] lim;
    s   = {1'b0, p} + HALF_P;
    r   = s[PW:F];
    lim = neg ? LIMN : LIMP;
    if (r > lim) rnd_f = neg ? CMIN : CMAX;
    else rnd_f = neg ? (~r[CW-1:0] + 1'b1) : r[CW-1:0];
  endfunction

  // configuration registers
  logic signed [CW-1:0] stretch_r, amplify_r, hmin_r, hmax_r;
  logic [1:0]           axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stretch_r <= CW'(6554);
      amplify_r <= '0;
      axis_r    <= AXIS_Z;
      hmin_r    <= '0;
      hmax_r    <= CW'(65536);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STRETCH: stretch_r <= cfg_wdata;
        REG_AMPLIFY: amplify_r <= cfg_wdata;
        REG_AXIS:    axis_r    <= cfg_wdata[1:0];
        REG_HMIN:    hmin_r    <= cfg_wdata;
        REG_HMAX:    hmax_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [1:0] ax;
  assign ax = (axis_r == AXIS_UNUSED) ? AXIS_Z : axis_r;

  // scale factor unit
  eng_state_t st_r, st_nxt;
  div_tgt_t   dtgt_r;
  logic signed [CW-1:0] amp_r, mr_r, xy_r, zs_r, k_r;
  logic [PW-1:0]        mp_r;
  logic [CW-1:0]        dist_r, den_r, drem_r, dq_r;
  logic                 degen_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 eng_busy;
  logic [CW-1:0]        smag;
  logic signed [CW-1:0] e_sum;
  logic [CW:0]          e_t;
  logic                 e_ge;
  logic [CW-1:0]        e_res;

  always_comb begin
    priority if (cfg_we) begin
      st_nxt = E_START;
    end else begin
      unique case (st_r)
        E_IDLE:  st_nxt = E_IDLE;
        E_START: st_nxt = amplify_r[CW-1] ? E_DIV : E_MUL;
        E_MUL:   st_nxt = E_RND;
        E_RND:   st_nxt = E_SUM;
        E_SUM:   st_nxt = E_DIV;
        E_DIV:   st_nxt = (dcnt_r == '0) ? E_DRND : E_DIV;
        E_DRND:  st_nxt = (dtgt_r == DT_AMP) ? E_MUL : E_K;
        E_K:     st_nxt = E_IDLE;
        default: st_nxt = E_IDLE;
      endcase
    end
  end

  always_comb begin
    eng_busy = (st_r != E_IDLE);
    smag     = mag_f(stretch_r);
    e_sum    = sat_f(sx_f(mr_r) + ONE_E);
    e_t      = {drem_r, (dcnt_r == DTOP)};
    e_ge     = e_t >= {1'b0, den_r};
    e_res    = dq_r + CW'({drem_r, 1'b0} >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= E_START;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      E_START: begin
        degen_r <= hmax_r <= hmin_r;
        dist_r  <= hmax_r - hmin_r;
        if (amplify_r[CW-1]) begin
          den_r  <= sat_f(ONE_E - sx_f(amplify_r));
          dtgt_r <= DT_AMP;
          drem_r <= '0;
          dq_r   <= '0;
          dcnt_r <= DTOP;
        end else begin
          amp_r <= sat_f(sx_f(amplify_r) + ONE_E);
        end
      end
      E_MUL: mp_r <= PW'(amp_r) * PW'(smag);
      E_RND: mr_r <= rnd_f(1'b0, mp_r);
      E_SUM: begin
        if (stretch_r[CW-1]) begin
          xy_r   <= e_sum;
          den_r  <= sat_f(ONE_E - sx_f(stretch_r));
          dtgt_r <= DT_ZS;
        end else begin
          zs_r   <= sat_f(sx_f(stretch_r) + ONE_E);
          den_r  <= e_sum;
          dtgt_r <= DT_XY;
        end
        drem_r <= '0;
        dq_r   <= '0;
        dcnt_r <= DTOP;
      end
      E_DIV: begin
        drem_r <= e_ge ? CW'(e_t - {1'b0, den_r}) : e_t[CW-1:0];
        dq_r   <= {dq_r[CW-2:0], e_ge};
        dcnt_r <= dcnt_r - 1'b1;
      end
      E_DRND: begin
        unique case (dtgt_r)
          DT_AMP:  amp_r <= e_res;
          DT_XY:   xy_r  <= e_res;
          DT_ZS:   zs_r  <= e_res;
          default: ;
        endcase
      end
      E_K: k_r <= sat_f(ONE_E - sx_f(xy_r));
      default: ;
    endcase
  end

  // vertex pipeline
  logic en;
  logic o_vld_r;
  assign en        = !o_vld_r || out_tready;
  assign in_tready = en && !eng_busy;

  logic                 a_vld_r, a_neg_r;
  logic [3*CW-1:0]      a_v_r;
  logic [CW:0]          a_x_r;
  logic signed [CW-1:0] in_p;
  logic signed [CW:0]   in_n;
  logic [CW:0]          a_hi;

  assign in_p = in_tdata[ax*CW +: CW];
  assign in_n = {in_p[CW-1], in_p} - {hmin_r[CW-1], hmin_r};
  assign a_hi = a_x_r >> (CW - F);

  logic            d_vld_r [0:CW];
  logic            d_neg_r [0:CW];
  logic            d_ovf_r [0:CW];
  logic [3*CW-1:0] d_v_r   [0:CW];
  logic [CW-1:0]   d_rem_r [0:CW];
  logic [CW-1:0]   d_q_r   [0:CW];
  logic [CW-1:0]   d_lo_r  [0:CW];
  logic [CW:0]     d_t     [0:CW-1];
  logic [CW:0]     d_df    [0:CW-1];
  logic            d_ge    [0:CW-1];
  logic [CW:0]     a_xs;

  assign a_xs = a_x_r << F;

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      d_t[i]  = {d_rem_r[i], d_lo_r[i][CW-1]};
      d_df[i] = d_t[i] - {1'b0, dist_r};
      d_ge[i] = d_t[i] >= {1'b0, dist_r};
    end
  end

  logic                 r_vld_r, o2_vld_r, t1_vld_r, t2_vld_r, m1_vld_r, m2_vld_r;
  logic                 f_vld_r, p1_vld_r;
  logic [3*CW-1:0]      r_v_r, o2_v_r, t1_v_r, t2_v_r, m1_v_r, m2_v_r, f_v_r;
  logic signed [CW-1:0] h_r, oh_h_r, oh_r, t_r, m_r, frac_r;
  logic [PW-1:0]        t_p_r, m_p_r;
  logic                 t_neg_r, m_neg_r;
  logic [PW-1:0]        p_p_r   [3];
  logic                 p_neg_r [3];
  logic [3*CW-1:0]      o_v_r;

  logic [CW:0]          r_q;
  logic signed [CW-1:0] r_h;
  logic signed [CW-1:0] f_sc;
  logic signed [CW-1:0] p_sc [3];

  always_comb begin
    r_q = {1'b0, d_q_r[CW]} + (CW+1)'({d_rem_r[CW], 1'b0} >= {1'b0, dist_r});
    if (degen_r) r_h = '0;
    else if (d_ovf_r[CW] || r_q > (d_neg_r[CW] ? QLIMN : QLIMP))
      r_h = d_neg_r[CW] ? CMIN : CMAX;
    else r_h = d_neg_r[CW] ? (~r_q[CW-1:0] + 1'b1) : r_q[CW-1:0];
    f_sc = sat_f(sx_f(m_r) <<< 2);
    for (int j = 0; j < 3; j++) begin
      p_sc[j] = (ax == 2'(j)) ? zs_r : frac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      for (int i = 0; i <= CW; i++) d_vld_r[i] <= 1'b0;
      r_vld_r  <= 1'b0;
      o2_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      f_vld_r  <= 1'b0;
      p1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_tvalid && in_tready;
      d_vld_r[0] <= a_vld_r;
      for (int i = 0; i < CW; i++) d_vld_r[i+1] <= d_vld_r[i];
      r_vld_r  <= d_vld_r[CW];
      o2_vld_r <= r_vld_r;
      t1_vld_r <= o2_vld_r;
      t2_vld_r <= t1_vld_r;
      m1_vld_r <= t2_vld_r;
      m2_vld_r <= m1_vld_r;
      f_vld_r  <= m2_vld_r;
      p1_vld_r <= f_vld_r;
      o_vld_r  <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_v_r   <= in_tdata[3*CW-1:0];
      a_neg_r <= in_n[CW];
      a_x_r   <= in_n[CW] ? (~in_n + 1'b1) : in_n;

      d_v_r[0]   <= a_v_r;
      d_neg_r[0] <= a_neg_r;
      d_ovf_r[0] <= a_hi >= {1'b0, dist_r};
      d_rem_r[0] <= (a_hi >= {1'b0, dist_r}) ? '0 : a_hi[CW-1:0];
      d_q_r[0]   <= '0;
      d_lo_r[0]  <= a_xs[CW-1:0];
      for (int i = 0; i < CW; i++) begin
        d_v_r[i+1]   <= d_v_r[i];
        d_neg_r[i+1] <= d_neg_r[i];
        d_ovf_r[i+1] <= d_ovf_r[i];
        d_rem_r[i+1] <= d_ge[i] ? d_df[i][CW-1:0] : d_t[i][CW-1:0];
        d_q_r[i+1]   <= {d_q_r[i][CW-2:0], d_ge[i]};
        d_lo_r[i+1]  <= {d_lo_r[i][CW-2:0], 1'b0};
      end

      r_v_r  <= d_v_r[CW];
      h_r    <= r_h;

      o2_v_r <= r_v_r;
      oh_h_r <= h_r;
      oh_r   <= sat_f(ONE_E - sx_f(h_r));

      t1_v_r  <= o2_v_r;
      t_p_r   <= PW'(mag_f(oh_h_r)) * PW'(mag_f(oh_r));
      t_neg_r <= oh_h_r[CW-1] ^ oh_r[CW-1];

      t2_v_r <= t1_v_r;
      t_r    <= rnd_f(t_neg_r, t_p_r);

      m1_v_r  <= t2_v_r;
      m_p_r   <= PW'(mag_f(k_r)) * PW'(mag_f(t_r));
      m_neg_r <= k_r[CW-1] ^ t_r[CW-1];

      m2_v_r <= m1_v_r;
      m_r    <= rnd_f(m_neg_r, m_p_r);

      f_v_r  <= m2_v_r;
      frac_r <= sat_f(ONE_E - sx_f(f_sc));

      for (int j = 0; j < 3; j++) begin
        p_p_r[j]   <= PW'(mag_f(f_v_r[j*CW +: CW])) * PW'(mag_f(p_sc[j]));
        p_neg_r[j] <= f_v_r[j*CW + CW - 1] ^ p_sc[j][CW-1];
        o_v_r[j*CW +: CW] <= rnd_f(p_neg_r[j], p_p_r[j]);
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = DW'(o_v_r);
  assign out_tuser  = degen_r;

endmodule

// ===== bench/asvd_checker.sv =====
module asvd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // in_x, in_y, in_z
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // out_x, out_y, out_z
  input  logic        out_tuser,  // degenerate_box
  input  logic        cfg_we,
  input  logic [asvd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import asvd_pkg::*;

  localparam longint ONE  = 64'sd65536;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        degen;
  } deformed_vertex_t;

  deformed_vertex_t deformed_q[$];

  longint    stretch_r, amplify_r, hmin_r, hmax_r;
  logic [1:0] axis_r;

  assign pending = deformed_q.size();

  function automatic longint clamp(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint signed_result(bit neg, logic [127:0] m);
    if (neg) begin
      if (m > 128'(-CMIN)) return CMIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'(CMAX)) return CMAX;
    return longint'(m[63:0]);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] x, y, p;
    x = 128'(a < 0 ? -a : a);
    y = 128'(b < 0 ? -b : b);
    p = (x * y + 128'd32768) >> 16;
    return signed_result((a < 0) != (b < 0), p);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] x, y, q, r;
    x = 128'(n < 0 ? -n : n) << 16;
    y = 128'(d < 0 ? -d : d);
    if (y == 0) return 0;
    q = x / y;
    r = x % y;
    if (r >= y - r) q = q + 1;
    return signed_result((n < 0) != (d < 0), q);
  endfunction

  function automatic deformed_vertex_t deform(logic [95:0] data);
    longint v[3];
    longint amp, xy, zs, h, k, t, m, frac, r;
    int ax;
    deformed_vertex_t res;
    v[0] = longint'($signed(data[31:0]));
    v[1] = longint'($signed(data[63:32]));
    v[2] = longint'($signed(data[95:64]));
    ax = (axis_r >= AXIS_Z) ? 2 : int'(axis_r);
    res.degen = (hmax_r <= hmin_r);
    if (amplify_r >= 0) amp = clamp(amplify_r + ONE);
    else amp = qdiv(ONE, clamp(ONE - amplify_r));
    if (stretch_r < 0) begin
      xy = clamp(qmul(amp, -stretch_r) + ONE);
      zs = qdiv(ONE, clamp(ONE - stretch_r));
    end else begin
      xy = qdiv(ONE, clamp(qmul(amp, stretch_r) + ONE));
      zs = clamp(stretch_r + ONE);
    end
    h = res.degen ? 0 : qdiv(v[ax] - hmin_r, hmax_r - hmin_r);
    k = clamp(ONE - xy);
    t = qmul(h, clamp(ONE - h));
    m = qmul(k, t);
    frac = clamp(ONE - clamp(4 * m));
    for (int j = 0; j < 3; j++) begin
      r = (j == ax) ? qmul(v[j], zs) : qmul(v[j], frac);
      v[j] = r;
    end
    res.x = v[0][31:0];
    res.y = v[1][31:0];
    res.z = v[2][31:0];
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    deformed_vertex_t want;
    if (!rst_n) begin
      stretch_r <= 6554;
      amplify_r <= 0;
      axis_r    <= AXIS_Z;
      hmin_r    <= 0;
      hmax_r    <= 65536;
      deformed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_STRETCH: stretch_r <= longint'($signed(cfg_wdata));
          REG_AMPLIFY: amplify_r <= longint'($signed(cfg_wdata));
          REG_AXIS:    axis_r    <= cfg_wdata[1:0];
          REG_HMIN:    hmin_r    <= longint'($signed(cfg_wdata));
          REG_HMAX:    hmax_r    <= longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deformed_q.push_back(deform(in_tdata));
      if (out_tvalid && out_tready) begin
        if (deformed_q.size() == 0) begin
          report("unexpected transaction", out_tdata[31:0], 32'h0);
        end else begin
          want = deformed_q.pop_front();
          if (out_tdata[31:0] !== want.x) report("out_x", out_tdata[31:0], want.x);
          if (out_tdata[63:32] !== want.y) report("out_y", out_tdata[63:32], want.y);
          if (out_tdata[95:64] !== want.z) report("out_z", out_tdata[95:64], want.z);
          if (out_tuser !== want.degen) report("degenerate_box", 32'(out_tuser), 32'(want.degen));
        end
      end
    end
  end
endmodule

// ===== bench/axis_stretch_vertex_deform_test.sv =====
module axis_stretch_vertex_deform_test;
  timeunit 1ns;
  timeprecision 1ps;
  import asvd_pkg::*;

  localparam logic [31:0] QMAX = 32'h7fffffff;
  localparam logic [31:0] QMIN = 32'h80000000;
  localparam logic [31:0] QONE = 32'h00010000;
  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  int          errors, pending;
  int          cycles = 0;
  int          vertices = 0;
  int          phases = 0;
  bit          calm = 1'b0;
  logic [31:0] box_lo, box_hi;
  logic [1:0]  axis_sel;

  always #4 clk = ~clk;

  axis_stretch_vertex_deform u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata
  );

  asvd_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_we, .cfg_addr, .cfg_wdata, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= calm || ($urandom_range(99) >= 34);
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    vertices++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_deform(logic [31:0] s, logic [31:0] a, logic [1:0] ax,
                            logic [31:0] lo, logic [31:0] hi);
    drain();
    write_reg(REG_STRETCH, s);
    write_reg(REG_AMPLIFY, a);
    write_reg(REG_AXIS, 32'(ax));
    write_reg(REG_HMIN, lo);
    write_reg(REG_HMAX, hi);
    cfg_we <= 1'b0;
    box_lo = lo;
    box_hi = hi;
    axis_sel = ax;
    phases++;
  endtask

  function automatic logic [31:0] small_q();
    return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
  endfunction

  task automatic random_vertices(int n);
    logic [31:0] c[3];
    logic [31:0] span;
    int ax;
    ax = (axis_sel >= AXIS_Z) ? 2 : int'(axis_sel);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 3; j++)
        c[j] = ($urandom_range(1) == 1) ? $urandom() : small_q();
      span = box_hi - box_lo;
      case ($urandom_range(4))
        0, 1: c[ax] = box_lo + (span == 0 ? 32'd0 : $urandom() % span);
        2: c[ax] = box_lo + 32'($signed($urandom_range(0, 64)) - 32);
        3: c[ax] = box_hi + 32'($signed($urandom_range(0, 64)) - 32);
        default: ;
      endcase
      send_vertex(c[0], c[1], c[2]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    box_lo = 32'd0;
    box_hi = QONE;
    axis_sel = AXIS_Z;

    send_vertex(32'd0, 32'd0, 32'd0);
    send_vertex(QMAX, QMAX, QMAX);
    send_vertex(QMIN, QMIN, QMIN);
    send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_vertex(QONE, QONE, 32'h00008000);
    send_vertex(QMAX, QMIN, QONE);
    send_vertex(QMIN, QMAX, 32'h00040000);
    send_vertex(QONE, QONE, 32'hfffc0000);
    send_vertex(32'h12345678, 32'hedcba987, 32'h00004000);
    send_vertex(32'h55555555, 32'haaaaaaaa, QMAX);

    set_deform(32'hffff0000, 32'hfffe0000, 2'd0, 32'hfffe0000, 32'h00020000);
    send_vertex(32'd0, QONE, QONE);
    send_vertex(32'hfffe0000, QMAX, QMIN);
    send_vertex(32'h00020000, QMIN, QMAX);
    set_deform(32'h00008000, 32'h00010000, 2'd1, 32'h00010000, 32'h00010000);
    send_vertex(QONE, QONE, QONE);
    send_vertex(QMAX, QMIN, QMAX);
    set_deform(32'h00010000, 32'd0, AXIS_UNUSED, QONE, 32'd0);
    send_vertex(QONE, QONE, 32'h00008000);
    send_vertex(QMIN, QMAX, QMIN);
    set_deform(QMIN, QMAX, 2'd0, QMIN, QMAX);
    send_vertex(QMIN, QMAX, QONE);
    send_vertex(QMAX, QONE, QMIN);
    send_vertex(32'd0, 32'hffffffff, 32'd1);
    set_deform(QMAX, QMIN, 2'd1, QMAX, QMIN);
    send_vertex(QMAX, QMAX, QMAX);
    send_vertex(32'd1, 32'd0, 32'hffffffff);

    for (int p = 0; p < 14; p++) begin
      calm = (p == 5);
      case (p % 4)
        0: set_deform(small_q(), small_q(), 2'($urandom_range(3)),
                      32'hfff00000, 32'h00100000);
        1: set_deform($urandom(), $urandom(), 2'($urandom_range(3)), $urandom(), $urandom());
        2: set_deform(32'($signed($urandom_range(0, 131072)) - 65536),
                      32'($signed($urandom_range(0, 131072)) - 65536),
                      2'($urandom_range(3)), small_q(), small_q());
        default: set_deform(small_q(), $urandom(), 2'($urandom_range(3)),
                            32'd0, 32'($urandom_range(1, 1000)));
      endcase
      random_vertices(62);
    end
    calm = 1'b0;

    drain();
    $display("covered %0d vertices over %0d register settings", vertices, phases + 1);
    $display("squash, stretch, all axis codes, degenerate and extreme boxes, random stalls");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
